@@ sv/uapf_pkg.sv @@
// shared types, constants and helpers for the unit-addressed pair framer
// no dependencies; imported by every module of the block except uapf_ram
`timescale 1ns / 1ps
`default_nettype none

package uapf_pkg;

  // field widths
  localparam int UNIT_W = 6;
  localparam int BYTE_W = 8;

  // default number of units
  localparam int NUM_UNITS_DEF = 64;

  // register map
  localparam logic REG_PAIR_TIMEOUT = 1'b0;
  localparam logic [BYTE_W-1:0] TIMEOUT_RESET = 8'd66;

  // event unit for take-event
  localparam logic [UNIT_W-1:0] EVENT_UNIT = 6'd2;

  // result kinds
  localparam logic [1:0] RES_TX       = 2'd0;
  localparam logic [1:0] RES_DISPATCH = 2'd1;
  localparam logic [1:0] RES_REPLY    = 2'd2;

  // operation codes
  typedef enum logic [2:0] {
    OP_RX         = 3'd0,
    OP_TICK       = 3'd1,
    OP_TX         = 3'd2,
    OP_SET_KIND   = 3'd3,
    OP_READ       = 3'd4,
    OP_TAKE_EVENT = 3'd5
  } op_t;

  // unit types
  typedef enum logic [2:0] {
    KIND_UNDEF = 3'd0,
    KIND_RESET = 3'd1,
    KIND_ERROR = 3'd2,
    KIND_ACK   = 3'd3,
    KIND_GPIO  = 3'd4,
    KIND_SPI   = 3'd5,
    KIND_I2C   = 3'd6,
    KIND_OTHER = 3'd7
  } kind_t;

  // framing phase
  typedef enum logic [1:0] {
    PH_UNIT    = 2'd0,
    PH_DATA    = 2'd1,
    PH_DISCARD = 2'd2
  } phase_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_LOOK  = 2'd1,
    ST_EMIT2 = 2'd2
  } seq_state_t;

  // one unit entry in the memory
  typedef struct packed {
    logic              handler;
    kind_t             kind;
    logic [BYTE_W-1:0] in_val;
    logic [BYTE_W-1:0] out_val;
  } entry_t;

  // memory access request from the sequencer
  typedef struct packed {
    logic              rd_en;
    logic [UNIT_W-1:0] rd_addr;
    logic              wr_en;
    logic [UNIT_W-1:0] wr_addr;
    entry_t            wr_data;
  } mem_req_t;

  // entry contents after reset
  function automatic entry_t reset_entry(input logic [UNIT_W-1:0] unit);
    entry_t e;
    e = '0;
    if (unit == 6'd0) begin
      e.kind = KIND_RESET;
    end else if (unit == 6'd1) begin
      e.kind = KIND_ERROR;
    end else if (unit == EVENT_UNIT) begin
      e.kind = KIND_ACK;
    end else begin
      e.kind = KIND_UNDEF;
    end
    return e;
  endfunction

endpackage

`default_nettype wire

@@ sv/unit_addressed_uart_pair_framer.sv @@
// top level of the unit-addressed pair framer
// depends on uapf_pkg, uapf_ram, uapf_regs, uapf_seq
`timescale 1ns / 1ps
`default_nettype none

// Frames a byte link as unit/data byte pairs and keeps per-unit type, input
// and output values in one on-chip memory. Issue a transaction by raising
// start while busy is low. The sequencer accepts it in ST_IDLE and issues the
// memory read, then takes the read data and writes the entry back in ST_LOOK;
// a transmit goes on to ST_EMIT2, since its unit byte and data byte leave as two
// results. The registered read of the unit memory is why the lookup has its own state. Results appear
// for exactly one cycle with result_valid high and cannot be held off, so the
// receiver must take every result on the cycle it is shown; last_of_run marks
// the final result of a transaction. The memory needs no clearing pass after
// reset: units never written read as their reset contents.
module unit_addressed_uart_pair_framer
  import uapf_pkg::*;
#(
  parameter int NUM_UNITS = NUM_UNITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        op,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic              line_error,
  input  wire logic [BYTE_W-1:0] unit_byte,
  input  wire logic [2:0]        unit_kind,
  input  wire logic              handler_enable,
  output logic                   result_valid,
  output logic      [1:0]        result_kind,
  output logic      [BYTE_W-1:0] result_byte,
  output logic      [UNIT_W-1:0] result_unit,
  output logic      [BYTE_W-1:0] stored_input,
  output logic      [BYTE_W-1:0] stored_output,
  output logic                   event_seen,
  output logic                   last_of_run,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  localparam int AW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;

  logic [BYTE_W-1:0] timeout_ticks;
  mem_req_t          mem_req;
  entry_t            rd_data;

  // configuration register
  uapf_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .timeout_ticks (timeout_ticks)
  );

  // unit entry memory
  uapf_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_UNITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr[AW-1:0]),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr[AW-1:0]),
    .rd_data (rd_data)
  );

  // framing sequencer
  uapf_seq #(
    .NUM_UNITS (NUM_UNITS)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .data_byte      (data_byte),
    .line_error     (line_error),
    .unit_byte      (unit_byte),
    .unit_kind      (unit_kind),
    .handler_enable (handler_enable),
    .timeout_ticks  (timeout_ticks),
    .mem_req        (mem_req),
    .rd_data        (rd_data),
    .result_valid   (result_valid),
    .result_kind    (result_kind),
    .result_byte    (result_byte),
    .result_unit    (result_unit),
    .stored_input   (stored_input),
    .stored_output  (stored_output),
    .event_seen     (event_seen),
    .last_of_run    (last_of_run)
  );

endmodule

`default_nettype wire

@@ sv/uapf_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module uapf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ sv/uapf_regs.sv @@
// apb configuration register: pair timeout in ticks
// depends on uapf_pkg
`timescale 1ns / 1ps
`default_nettype none

module uapf_regs
  import uapf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output logic      [BYTE_W-1:0] timeout_ticks
);

  logic reg_wr;

  // write transaction to the timeout register
  assign reg_wr = psel && penable && pwrite && (paddr[2] == REG_PAIR_TIMEOUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (reg_wr) begin
      timeout_ticks <= pwdata[BYTE_W-1:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_PAIR_TIMEOUT) begin
      prdata = {{(32-BYTE_W){1'b0}}, timeout_ticks};
    end
  end

  assign pready = 1'b1;

endmodule

`default_nettype wire

@@ sv/uapf_seq.sv @@
// sequencer: framing state, read-modify-write of unit entries, result output
// depends on uapf_pkg; drives the unit memory through mem_req_t
`timescale 1ns / 1ps
`default_nettype none

module uapf_seq
  import uapf_pkg::*;
#(
  parameter int NUM_UNITS = NUM_UNITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        op,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic              line_error,
  input  wire logic [BYTE_W-1:0] unit_byte,
  input  wire logic [2:0]        unit_kind,
  input  wire logic              handler_enable,
  input  wire logic [BYTE_W-1:0] timeout_ticks,
  output mem_req_t               mem_req,
  input  wire entry_t            rd_data,
  output logic                   result_valid,
  output logic      [1:0]        result_kind,
  output logic      [BYTE_W-1:0] result_byte,
  output logic      [UNIT_W-1:0] result_unit,
  output logic      [BYTE_W-1:0] stored_input,
  output logic      [BYTE_W-1:0] stored_output,
  output logic                   event_seen,
  output logic                   last_of_run
);

  localparam int AW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
  localparam logic [UNIT_W:0] UNIT_LIM = (UNIT_W+1)'(NUM_UNITS);

  seq_state_t state, state_next;
  phase_t     frame_phase, phase_next;
  logic [UNIT_W-1:0] held_unit, held_next;
  logic              timeout_armed, armed_next;
  logic [BYTE_W-1:0] timeout_left, left_next;
  logic [NUM_UNITS-1:0] valid;

  // latched transaction
  logic [2:0]        op_q;
  logic [BYTE_W-1:0] data_q;
  logic              err_q;
  logic [BYTE_W-1:0] ubyte_q;
  logic [2:0]        kind_q;
  logic              hen_q;
  logic [UNIT_W-1:0] addr_q;
  logic              vld_q;

  logic              accept;
  logic [UNIT_W-1:0] rd_addr;
  logic              rd_in_range;
  logic              rd_vld;
  logic              in_range;
  entry_t            ent, ent_mod;

  logic              res_valid_next, res_ev_next, res_last_next;
  logic [1:0]        res_kind_next;
  logic [BYTE_W-1:0] res_byte_next, res_in_next, res_out_next;
  logic [UNIT_W-1:0] res_unit_next;

  assign busy   = (state != ST_IDLE);
  assign accept = start && (state == ST_IDLE);

  // entry address of the incoming transaction
  always_comb begin
    if ((op_t'(op) == OP_RX) && (frame_phase == PH_DATA)) begin
      rd_addr = held_unit;
    end else if (op_t'(op) == OP_TAKE_EVENT) begin
      rd_addr = EVENT_UNIT;
    end else begin
      rd_addr = unit_byte[UNIT_W-1:0];
    end
  end

  assign rd_in_range = ({1'b0, rd_addr} < UNIT_LIM);
  assign rd_vld      = rd_in_range ? valid[rd_addr[AW-1:0]] : 1'b0;
  assign in_range    = ({1'b0, addr_q} < UNIT_LIM);

  // entry never written reads as its reset contents
  assign ent = vld_q ? rd_data : reset_entry(addr_q);

  // capture transaction fields
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= op;
      data_q  <= data_byte;
      err_q   <= line_error;
      ubyte_q <= unit_byte;
      kind_q  <= unit_kind;
      hen_q   <= handler_enable;
      addr_q  <= rd_addr;
      vld_q   <= rd_vld;
    end
  end

  // control state and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      frame_phase   <= PH_UNIT;
      held_unit     <= '0;
      timeout_armed <= 1'b0;
      timeout_left  <= '0;
      valid         <= '0;
      result_valid  <= 1'b0;
    end else begin
      state         <= state_next;
      frame_phase   <= phase_next;
      held_unit     <= held_next;
      timeout_armed <= armed_next;
      timeout_left  <= left_next;
      result_valid  <= res_valid_next;
      if (mem_req.wr_en) begin
        valid[addr_q[AW-1:0]] <= 1'b1;
      end
    end
  end

  // result payload registers
  always_ff @(posedge clk) begin
    result_kind   <= res_kind_next;
    result_byte   <= res_byte_next;
    result_unit   <= res_unit_next;
    stored_input  <= res_in_next;
    stored_output <= res_out_next;
    event_seen    <= res_ev_next;
    last_of_run   <= res_last_next;
  end

  // next state, memory access and results
  always_comb begin
    state_next     = state;
    phase_next     = frame_phase;
    held_next      = held_unit;
    armed_next     = timeout_armed;
    left_next      = timeout_left;
    ent_mod        = ent;
    mem_req        = '0;
    res_valid_next = 1'b0;
    res_kind_next  = RES_TX;
    res_byte_next  = '0;
    res_unit_next  = addr_q;
    res_in_next    = '0;
    res_out_next   = '0;
    res_ev_next    = 1'b0;
    res_last_next  = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = rd_addr;
          state_next      = ST_LOOK;
        end
      end

      ST_LOOK: begin
        state_next = ST_IDLE;
        case (op_t'(op_q))
          OP_RX: begin
            case (frame_phase)
              PH_UNIT: begin
                held_next  = data_q[UNIT_W-1:0];
                phase_next = (err_q || (data_q[7:6] != 2'b00)) ? PH_DISCARD : PH_DATA;
                armed_next = 1'b1;
                left_next  = timeout_ticks;
              end
              PH_DATA: begin
                phase_next = PH_UNIT;
                armed_next = 1'b0;
                if (!err_q && in_range && (ent.kind != KIND_UNDEF)) begin
                  case (ent.kind) inside
                    KIND_GPIO, KIND_I2C: begin
                      ent_mod.in_val = data_q;
                      mem_req.wr_en  = 1'b1;
                    end
                    KIND_ACK: begin
                      ent_mod.in_val     = data_q;
                      ent_mod.out_val[7] = 1'b1;
                      mem_req.wr_en      = 1'b1;
                    end
                    default: begin
                    end
                  endcase
                  if (ent.handler) begin
                    res_valid_next = 1'b1;
                    res_kind_next  = RES_DISPATCH;
                    res_byte_next  = data_q;
                    res_last_next  = 1'b1;
                  end
                end
              end
              default: begin
                // discard phase, also the unused phase code
                phase_next = PH_UNIT;
                armed_next = 1'b0;
              end
            endcase
          end

          OP_TICK: begin
            if (timeout_armed) begin
              if (timeout_left <= 8'd1) begin
                left_next  = '0;
                armed_next = 1'b0;
                phase_next = PH_UNIT;
              end else begin
                left_next = timeout_left - 8'd1;
              end
            end
          end

          OP_TX: begin
            if (in_range) begin
              if (((ent.kind == KIND_GPIO) && !ubyte_q[6]) ||
                  ((ent.kind == KIND_SPI) && ubyte_q[6]) ||
                  ((ent.kind == KIND_I2C) && ubyte_q[6])) begin
                ent_mod.out_val = data_q;
                mem_req.wr_en   = 1'b1;
              end else if (ent.kind == KIND_ACK) begin
                ent_mod.out_val[0] = (data_q != 8'd0);
                mem_req.wr_en      = 1'b1;
              end
              res_valid_next = 1'b1;
              res_kind_next  = RES_TX;
              res_byte_next  = ubyte_q;
              state_next     = ST_EMIT2;
            end
          end

          OP_SET_KIND: begin
            if (in_range) begin
              ent_mod.handler = hen_q;
              ent_mod.kind    = kind_t'(kind_q);
              mem_req.wr_en   = 1'b1;
            end
          end

          OP_READ: begin
            res_valid_next = 1'b1;
            res_kind_next  = RES_REPLY;
            res_last_next  = 1'b1;
            if (in_range) begin
              res_in_next  = ent.in_val;
              res_out_next = ent.out_val;
            end
          end

          OP_TAKE_EVENT: begin
            ent_mod.out_val[7] = 1'b0;
            mem_req.wr_en      = 1'b1;
            res_valid_next     = 1'b1;
            res_kind_next      = RES_REPLY;
            res_in_next        = ent_mod.in_val;
            res_out_next       = ent_mod.out_val;
            res_ev_next        = ent.out_val[7];
            res_last_next      = 1'b1;
          end

          default: begin
          end
        endcase
      end

      ST_EMIT2: begin
        // data byte of a transmit pair
        res_valid_next = 1'b1;
        res_kind_next  = RES_TX;
        res_byte_next  = data_q;
        res_last_next  = 1'b1;
        state_next     = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    mem_req.wr_addr = addr_q;
    mem_req.wr_data = ent_mod;
  end

`ifndef ASSERT_OFF
  // results come only out of the lookup or second transmit cycle
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(state) == ST_LOOK) || ($past(state) == ST_EMIT2))
    else $error("result without a preceding lookup");

  // second transmit byte always follows a lookup
  a_emit_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT2) |-> ($past(state) == ST_LOOK))
    else $error("second transmit byte out of order");

  // write-back only after the read data has arrived
  a_wr_in_look: assert property (@(posedge clk) disable iff (rst)
    mem_req.wr_en |-> (state == ST_LOOK))
    else $error("memory write outside lookup");

  // a pending pair always has a running timeout
  a_phase_armed: assert property (@(posedge clk) disable iff (rst)
    !timeout_armed |-> (frame_phase == PH_UNIT))
    else $error("pair pending without armed timeout");
`endif

endmodule

`default_nettype wire
